[hw/rtl/fis_pkg.sv]
// Package for the fault isolation supervisor: health codes, event opcodes,
// register indexes and field widths. No dependencies.
`default_nettype none

package fis_pkg;

	// Width of the elapsed-tick counter (legal range 8 to 32)
	localparam int TICK_COUNT_WIDTH = 16;

	localparam int OPCODE_W   = 3;
	localparam int HEALTH_W   = 3;
	localparam int FAIL_W     = 16;
	localparam int ATTEMPT_W  = 8;
	localparam int DELAY_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Width in which elapsed ticks and the delay register are compared
	localparam int TICK_CMP_W = (TICK_COUNT_WIDTH > DELAY_W) ? TICK_COUNT_WIDTH : DELAY_W;

	typedef enum logic [HEALTH_W-1:0] {
		HEALTHY    = 3'd0,
		DEGRADED   = 3'd1,
		SUSPENDED  = 3'd2,
		RECOVERING = 3'd3,
		TERMINATED = 3'd4
	} health_t;

	localparam logic [OPCODE_W-1:0] OP_SUCCESS    = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_FAILURE    = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_BEGIN_RCVR = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_END_RCVR   = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS   = 2'd2;

	localparam logic [FAIL_W-1:0]    FAIL_THRESHOLD_RST = 16'd20;
	localparam logic [DELAY_W-1:0]   RECOVERY_DELAY_RST = 16'd1000;
	localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST   = 8'd3;

endpackage

`default_nettype wire

[hw/rtl/fis_evt_if.sv]
// Event channel of the fault isolation supervisor: valid/ready plus event fields.
// Depends on fis_pkg.
`default_nettype none

interface fis_evt_if;
	logic                          valid;
	logic                          ready;
	logic [fis_pkg::OPCODE_W-1:0]  opcode;
	logic                          recovery_ok;

	modport source (output valid, output opcode, output recovery_ok, input ready);
	modport sink   (input valid, input opcode, input recovery_ok, output ready);
endinterface

`default_nettype wire

[hw/rtl/fis_rpt_if.sv]
// Status report channel of the fault isolation supervisor: valid/ready plus status fields.
// Depends on fis_pkg.
`default_nettype none

interface fis_rpt_if;
	logic                          valid;
	logic                          ready;
	logic [fis_pkg::HEALTH_W-1:0]  health_code;
	logic                          may_process;
	logic                          may_recover;
	logic                          recovery_granted;
	logic [fis_pkg::FAIL_W-1:0]    failure_total;
	logic [fis_pkg::ATTEMPT_W-1:0] attempt_total;

	modport source (output valid, output health_code, output may_process, output may_recover,
		output recovery_granted, output failure_total, output attempt_total, input ready);
	modport sink   (input valid, input health_code, input may_process, input may_recover,
		input recovery_granted, input failure_total, input attempt_total, output ready);
endinterface

`default_nettype wire

[hw/rtl/fis_cfg_if.sv]
// Register write channel of the fault isolation supervisor: valid/ready, index, data.
// Depends on fis_pkg.
`default_nettype none

interface fis_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fis_pkg::CFG_IDX_W-1:0]   reg_index;
	logic [fis_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output reg_index, output data, input ready);
	modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/fault_isolation_supervisor.sv]
// Fault isolation supervisor top level: circuit breaker with a retry limit.
// Depends on fis_pkg, fis_evt_if, fis_rpt_if and fis_cfg_if.
//
// The block takes one event per transfer on evt (success, failure, tick, begin
// recovery, end recovery, clear; unused opcodes only report) and returns exactly
// one status report per event on rpt, showing the state after that event. It
// sustains one event per clock cycle while rpt stays ready: an event is captured
// in the input stage (_s1), the next health state and counters are worked out in
// one pass of compare and increment logic against the state registers, and the
// report is held in the result register (_s2) until rpt transfers. The loop that
// sets the rate is the state register feedback through that single pass.
// evt.ready drops only while a captured event waits behind an untaken report.
// Registers are written through cfg (index 0 failure threshold, 1 recovery delay
// in ticks, 2 max recovery attempts; index 3 is ignored), which is always ready;
// write them only while no event is in flight. Clear resets health and counters
// but keeps registers.
`default_nettype none

module fault_isolation_supervisor (
	input  wire          clk,
	input  wire          arst_n,
	fis_evt_if.sink      evt,
	fis_rpt_if.source    rpt,
	fis_cfg_if.sink      cfg
);

	localparam int TW = fis_pkg::TICK_COUNT_WIDTH;
	localparam int CW = fis_pkg::TICK_CMP_W;

	// Configuration registers
	logic [fis_pkg::FAIL_W-1:0]    fail_threshold_q;
	logic [fis_pkg::DELAY_W-1:0]   recovery_delay_q;
	logic [fis_pkg::ATTEMPT_W-1:0] max_attempts_q;

	// Supervisor state
	fis_pkg::health_t              health_q;
	logic [fis_pkg::FAIL_W-1:0]    fail_cnt_q;
	logic [fis_pkg::ATTEMPT_W-1:0] attempt_cnt_q;
	logic [TW-1:0]                 elapsed_q;

	// Input stage
	logic                          valid_s1;
	logic [fis_pkg::OPCODE_W-1:0]  opcode_s1;
	logic                          recovery_ok_s1;

	// Result stage
	logic                          valid_s2;
	fis_pkg::health_t              health_s2;
	logic                          may_process_s2;
	logic                          may_recover_s2;
	logic                          granted_s2;
	logic [fis_pkg::FAIL_W-1:0]    fail_total_s2;
	logic [fis_pkg::ATTEMPT_W-1:0] attempt_total_s2;

	// Next-state logic
	fis_pkg::health_t              health_nxt;
	logic [fis_pkg::FAIL_W-1:0]    fail_cnt_nxt;
	logic [fis_pkg::ATTEMPT_W-1:0] attempt_cnt_nxt;
	logic [TW-1:0]                 elapsed_nxt;
	logic                          granted_nxt;
	logic [fis_pkg::FAIL_W-1:0]    fail_inc;
	logic [fis_pkg::ATTEMPT_W-1:0] attempt_inc;
	logic [TW-1:0]                 elapsed_inc;
	logic                          attempts_used_up;
	logic                          may_recover_nxt;

	logic advance_s1;
	logic take_evt;

	// Advance the input stage when the result register is free or being taken
	assign advance_s1 = valid_s1 && (!valid_s2 || rpt.ready);
	assign evt.ready  = !valid_s1 || advance_s1;
	assign take_evt   = evt.valid && evt.ready;
	assign cfg.ready  = 1'b1;

	// Saturating increments
	assign fail_inc    = (&fail_cnt_q)    ? fail_cnt_q    : fail_cnt_q + 1'b1;
	assign attempt_inc = (&attempt_cnt_q) ? attempt_cnt_q : attempt_cnt_q + 1'b1;
	assign elapsed_inc = (&elapsed_q)     ? elapsed_q     : elapsed_q + 1'b1;

	assign attempts_used_up = attempt_cnt_q >= max_attempts_q;

	always_comb begin
		health_nxt      = health_q;
		fail_cnt_nxt    = fail_cnt_q;
		attempt_cnt_nxt = attempt_cnt_q;
		elapsed_nxt     = elapsed_q;
		granted_nxt     = 1'b0;
		case (opcode_s1)
			fis_pkg::OP_SUCCESS: begin
				fail_cnt_nxt = '0;
				if (health_q inside {fis_pkg::DEGRADED, fis_pkg::RECOVERING}) begin
					health_nxt      = fis_pkg::HEALTHY;
					attempt_cnt_nxt = '0;
				end
			end
			fis_pkg::OP_FAILURE: begin
				fail_cnt_nxt = fail_inc;
				if (fail_inc >= fail_threshold_q) begin
					// Threshold reached: trip a running block into suspension
					if (health_q inside {fis_pkg::HEALTHY, fis_pkg::DEGRADED}) begin
						health_nxt  = fis_pkg::SUSPENDED;
						elapsed_nxt = '0;
					end
				end else if (health_q == fis_pkg::HEALTHY) begin
					health_nxt = fis_pkg::DEGRADED;
				end
			end
			fis_pkg::OP_TICK: begin
				elapsed_nxt = elapsed_inc;
			end
			fis_pkg::OP_BEGIN_RCVR: begin
				if (health_q == fis_pkg::RECOVERING) begin
					if (attempts_used_up)
						health_nxt = fis_pkg::TERMINATED;
				end else if (health_q == fis_pkg::SUSPENDED) begin
					if (attempts_used_up) begin
						health_nxt = fis_pkg::TERMINATED;
					end else begin
						attempt_cnt_nxt = attempt_inc;
						health_nxt      = fis_pkg::RECOVERING;
						granted_nxt     = 1'b1;
					end
				end
			end
			fis_pkg::OP_END_RCVR: begin
				if (health_q == fis_pkg::RECOVERING) begin
					if (recovery_ok_s1) begin
						health_nxt      = fis_pkg::HEALTHY;
						fail_cnt_nxt    = '0;
						attempt_cnt_nxt = '0;
					end else begin
						// Failed recovery falls back to suspension, or ends it all
						elapsed_nxt = '0;
						health_nxt  = attempts_used_up ? fis_pkg::TERMINATED
							: fis_pkg::SUSPENDED;
					end
				end
			end
			fis_pkg::OP_CLEAR: begin
				health_nxt      = fis_pkg::HEALTHY;
				fail_cnt_nxt    = '0;
				attempt_cnt_nxt = '0;
				elapsed_nxt     = '0;
			end
			default: begin
				// Unused opcodes: report only
			end
		endcase
	end

	assign may_recover_nxt = (health_nxt == fis_pkg::SUSPENDED) &&
		(CW'(elapsed_nxt) >= CW'(recovery_delay_q));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_threshold_q <= fis_pkg::FAIL_THRESHOLD_RST;
			recovery_delay_q <= fis_pkg::RECOVERY_DELAY_RST;
			max_attempts_q   <= fis_pkg::MAX_ATTEMPTS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				fis_pkg::REG_FAIL_THRESHOLD: fail_threshold_q <= cfg.data;
				fis_pkg::REG_RECOVERY_DELAY: recovery_delay_q <= cfg.data;
				fis_pkg::REG_MAX_ATTEMPTS:   max_attempts_q   <= cfg.data[fis_pkg::ATTEMPT_W-1:0];
				default: begin
					// Drop writes to unmapped indexes
				end
			endcase
		end
	end

	// State, stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q      <= fis_pkg::HEALTHY;
			fail_cnt_q    <= '0;
			attempt_cnt_q <= '0;
			elapsed_q     <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			if (advance_s1) begin
				health_q      <= health_nxt;
				fail_cnt_q    <= fail_cnt_nxt;
				attempt_cnt_q <= attempt_cnt_nxt;
				elapsed_q     <= elapsed_nxt;
			end
			if (take_evt)
				valid_s1 <= 1'b1;
			else if (advance_s1)
				valid_s1 <= 1'b0;
			if (advance_s1)
				valid_s2 <= 1'b1;
			else if (rpt.ready)
				valid_s2 <= 1'b0;
		end
	end

	// Payload registers: hold the event and the report
	always_ff @(posedge clk) begin
		if (take_evt) begin
			opcode_s1      <= evt.opcode;
			recovery_ok_s1 <= evt.recovery_ok;
		end
		if (advance_s1) begin
			health_s2        <= health_nxt;
			may_process_s2   <= (health_nxt == fis_pkg::HEALTHY) ||
				(health_nxt == fis_pkg::DEGRADED);
			may_recover_s2   <= may_recover_nxt;
			granted_s2       <= granted_nxt;
			fail_total_s2    <= fail_cnt_nxt;
			attempt_total_s2 <= attempt_cnt_nxt;
		end
	end

	assign rpt.valid            = valid_s2;
	assign rpt.health_code      = health_s2;
	assign rpt.may_process      = may_process_s2;
	assign rpt.may_recover      = may_recover_s2;
	assign rpt.recovery_granted = granted_s2;
	assign rpt.failure_total    = fail_total_s2;
	assign rpt.attempt_total    = attempt_total_s2;

endmodule

`default_nettype wire
